@@ hw/rtl/pdfr_pkg.sv @@
// Shared types and constants for the Pelco-D frame receiver.
`default_nettype none

package pdfr_pkg;

  localparam int unsigned FrameBodyBytes = 6;
  localparam int unsigned StoreDepth     = FrameBodyBytes - 1;
  localparam int unsigned CountWidth     = $clog2(FrameBodyBytes);

  localparam logic [7:0]  SyncByte       = 8'hFF;
  localparam logic [7:0]  DevAddrReset   = 8'd1;
  localparam logic [15:0] TimeoutReset   = 16'd200;

  // Input command codes.
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Configuration register indexes.
  localparam logic CfgDevAddr = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusChecksum = 2'd1,
    StatusAddress  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] frame_address;
    logic [7:0] command_one;
    logic [7:0] command_two;
    logic [7:0] data_one;
    logic [7:0] data_two;
    status_e    status;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pelco_d_frame_receiver.sv @@
// Top level of the Pelco-D frame receiver.
//
// Input channel: one transaction is either a received byte (command 0) or
// one timer tick (command 1). The receiver hunts for the sync byte 0xFF,
// then collects address, two command bytes, two data bytes and checksum.
// Output channel: one transaction per completed frame, carrying the four
// frame bytes and the address plus a status (ok, checksum mismatch, or
// address mismatch; checksum is checked first).
// The checksum byte's result goes to the result register, or to the skid
// register if that is held. One input transaction is taken every cycle
// if ready is high; parser state updates in a single pass at acceptance.
// A skid register behind the result register lets input continue while a
// result waits; input ready drops only when both result slots are full.
// Ticks with no byte for timeout_ticks drop a partial frame.
// Reset returns the parser to sync hunt, empties the result buffer and
// loads device address 1 and timeout 200. Configuration writes take effect
// at the next clock edge.
`default_nettype none

module pelco_d_frame_receiver (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire [15:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         command_i,
  input  wire [7:0]   rx_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  frame_address_o,
  output logic [7:0]  command_one_o,
  output logic [7:0]  command_two_o,
  output logic [7:0]  data_one_o,
  output logic [7:0]  data_two_o,
  output logic [1:0]  status_o
);

  logic              item_fire;
  logic              res_valid;
  pdfr_pkg::result_t res;
  pdfr_pkg::result_t out_data;

  assign item_fire = in_valid_i & in_ready_o;

  pdfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_fire_i (item_fire),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pdfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign frame_address_o = out_data.frame_address;
  assign command_one_o   = out_data.command_one;
  assign command_two_o   = out_data.command_two;
  assign data_one_o      = out_data.data_one;
  assign data_two_o      = out_data.data_two;
  assign status_o        = out_data.status;

endmodule

`default_nettype wire

@@ hw/rtl/pdfr_core.sv @@
// Frame parser: sync hunt, byte collection, timeout and result decode.
`default_nettype none

module pdfr_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_index_i,
  input  wire [15:0]          cfg_data_i,
  input  wire                 item_fire_i,
  input  wire                 command_i,
  input  wire [7:0]           rx_byte_i,
  output logic                res_valid_o,
  output pdfr_pkg::result_t   res_o
);

  localparam int unsigned CW = pdfr_pkg::CountWidth;

  logic [7:0]    dev_addr_q;
  logic [15:0]   timeout_q;
  logic          receiving_q, receiving_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   idle_q, idle_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    store_q [pdfr_pkg::StoreDepth];
  logic          store_we;
  logic [16:0]   idle_next;
  logic          last_byte;

  assign idle_next = {1'b0, idle_q} + 17'd1;
  assign last_byte = (count_q == CW'(pdfr_pkg::StoreDepth));

  always_comb begin
    receiving_d = receiving_q;
    count_d     = count_q;
    idle_d      = idle_q;
    sum_d       = sum_q;
    store_we    = 1'b0;
    res_valid_o = 1'b0;
    if (item_fire_i) begin
      if (command_i == pdfr_pkg::CmdTick) begin
        if (receiving_q) begin
          if (idle_next >= {1'b0, timeout_q}) begin
            receiving_d = 1'b0;
            count_d     = '0;
            idle_d      = '0;
            sum_d       = '0;
          end else begin
            idle_d = idle_next[15:0];
          end
        end
      end else if (!receiving_q) begin
        if (rx_byte_i == pdfr_pkg::SyncByte) begin
          receiving_d = 1'b1;
          count_d     = '0;
          idle_d      = '0;
          sum_d       = '0;
        end
      end else if (!last_byte) begin
        idle_d   = '0;
        store_we = 1'b1;
        sum_d    = sum_q + rx_byte_i;
        count_d  = count_q + CW'(1);
      end else begin
        // Checksum byte closes the frame.
        res_valid_o = 1'b1;
        receiving_d = 1'b0;
        count_d     = '0;
        idle_d      = '0;
        sum_d       = '0;
      end
    end
  end

  always_comb begin
    res_o.frame_address = store_q[0];
    res_o.command_one   = store_q[1];
    res_o.command_two   = store_q[2];
    res_o.data_one      = store_q[3];
    res_o.data_two      = store_q[4];
    priority if (rx_byte_i != sum_q) begin
      res_o.status = pdfr_pkg::StatusChecksum;
    end else if (store_q[0] != dev_addr_q) begin
      res_o.status = pdfr_pkg::StatusAddress;
    end else begin
      res_o.status = pdfr_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= pdfr_pkg::DevAddrReset;
      timeout_q   <= pdfr_pkg::TimeoutReset;
      receiving_q <= 1'b0;
      count_q     <= '0;
      idle_q      <= '0;
      sum_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pdfr_pkg::CfgDevAddr: dev_addr_q <= cfg_data_i[7:0];
          pdfr_pkg::CfgTimeout: timeout_q  <= cfg_data_i;
          default: ;
        endcase
      end
      receiving_q <= receiving_d;
      count_q     <= count_d;
      idle_q      <= idle_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pdfr_out_buf.sv @@
// Result register with a skid stage so the parser keeps running while one result waits under backpressure.
`default_nettype none

module pdfr_out_buf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire pdfr_pkg::result_t push_data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output pdfr_pkg::result_t   out_data_o
);

  logic              main_vld_q, skid_vld_q;
  pdfr_pkg::result_t main_q, skid_q;
  logic              pop;

  assign pop         = main_vld_q & out_ready_i;
  assign space_o     = ~skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_vld_q <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      main_q <= skid_vld_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire
